// ===== rtl/core/sgis_pkg.sv =====
// Shared types and constants for the sorted grid interval search core.
// Used by the compare unit, the sequencer and the top level.
package sgis_pkg;

   localparam int GRID_DEPTH_DEF  = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int COUNT_W   = 11;
   localparam int POS_W     = 10;
   localparam int INDEX_W   = 10;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] GRID_COUNT_RESET = 11'd1024;

   // Function codes of an input item.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Register index decoded from the word address.
   localparam logic CSR_IDX_GRID_COUNT = 1'b0;

   // Outcome of comparing one grid entry (probe) against the search key.
   typedef struct packed {
      logic probe_lt;   // probe is below the key
      logic probe_eq;   // probe equals the key
   } cmp_res_type;

endpackage

// ===== rtl/core/sgis_grid_mem.sv =====
// Single-port-write, single-port-read grid memory with registered read data.
// Depends on nothing but its parameters.
module sgis_grid_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sgis_cmp_unit.sv =====
// Shared signed comparator: checks one grid entry against the search key.
// Depends on sgis_pkg for the result struct.
module sgis_cmp_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] probe,
   output sgis_pkg::cmp_res_type         res
);
   import sgis_pkg::*;

   always_comb begin
      res.probe_lt = probe < key;
      res.probe_eq = probe == key;
   end

endmodule

// ===== rtl/core/sgis_seq.sv =====
// Sequencer for grid writes and bisection queries over the grid memory.
// Depends on sgis_pkg; drives the memory ports and reads the compare unit.
module sgis_seq #(
   parameter int GRID_DEPTH  = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [sgis_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic [sgis_pkg::COUNT_W-1:0]        grid_count,
   input  sgis_pkg::cmp_res_type               cmp_res,
   output logic signed [VALUE_WIDTH-1:0]       key,
   output logic                                wr_en,
   output logic [$clog2(GRID_DEPTH)-1:0]       wr_addr,
   output logic [VALUE_WIDTH-1:0]              wr_data,
   output logic                                rd_en,
   output logic [$clog2(GRID_DEPTH)-1:0]       rd_addr,
   output logic                                rsp_valid,
   output logic [sgis_pkg::POS_W-1:0]          rsp_position
);
   import sgis_pkg::*;

   localparam int IDX_W = $clog2(GRID_DEPTH);
   localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(GRID_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [IDX_W-1:0]              last_ff, last_in;
   logic [IDX_W-1:0]              left_ff, left_in;
   logic [IDX_W-1:0]              right_ff, right_in;
   logic [IDX_W-1:0]              mid_ff, mid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]              rsp_position_ff, rsp_position_in;

   logic [COUNT_W-1:0] count_used;
   logic [IDX_W:0]     range_sum;
   logic [IDX_W-1:0]   range_span;
   logic [IDX_W-1:0]   range_mid;
   logic               query_accept;

   // Clamp the configured count to 1..GRID_DEPTH and keep the last used index.
   always_comb begin
      count_used = (grid_count == '0) ? COUNT_W'(1) : grid_count;
      if (32'(count_used) > 32'(GRID_DEPTH)) begin
         last_in = LAST_MAX;
      end else begin
         last_in = IDX_W'(count_used - COUNT_W'(1));
      end
   end

   // The next bracket comes from the probe outcome; its midpoint feeds the next read.
   always_comb begin
      if (state_ff == ST_PROBE) begin
         left_in  = cmp_res.probe_lt ? mid_ff : left_ff;
         right_in = cmp_res.probe_lt ? right_ff : mid_ff;
      end else begin
         left_in  = '0;
         right_in = last_ff;
      end
      range_sum  = {1'b0, left_in} + {1'b0, right_in};
      range_mid  = range_sum[IDX_W:1];
      range_span = right_in - left_in;
   end

   assign query_accept = start && (state_ff == ST_IDLE) && (req_func == FUNC_QUERY);

   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      mid_in          = mid_ff;
      rsp_valid_in    = 1'b0;
      rsp_position_in = rsp_position_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_func == FUNC_WRITE)) begin
               wr_en = 32'(req_entry_index) < 32'(GRID_DEPTH);
            end else if (query_accept) begin
               key_in   = req_value;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (!cmp_res.probe_lt && !cmp_res.probe_eq) begin
               // Key lies below the first entry.
               rsp_valid_in    = 1'b1;
               rsp_position_in = '0;
               state_in        = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = last_ff;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (cmp_res.probe_lt) begin
               // Key lies above the last used entry.
               rsp_valid_in    = 1'b1;
               rsp_position_in = POS_W'(last_ff);
               state_in        = ST_IDLE;
            end else if (range_span > IDX_W'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = range_mid;
               mid_in   = range_mid;
               state_in = ST_PROBE;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = '0;
               state_in        = ST_IDLE;
            end
         end
         ST_PROBE: begin
            if (cmp_res.probe_eq) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = POS_W'(mid_ff);
               state_in        = ST_IDLE;
            end else if (range_span > IDX_W'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = range_mid;
               mid_in   = range_mid;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = POS_W'(left_in);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff          <= key_in;
      mid_ff          <= mid_in;
      rsp_position_ff <= rsp_position_in;
      if (query_accept) begin
         last_ff <= last_in;
      end
      if (state_ff == ST_LAST || state_ff == ST_PROBE) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign busy         = state_ff != ST_IDLE;
   assign key          = key_ff;
   assign wr_addr      = IDX_W'(req_entry_index);
   assign wr_data      = req_value;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== rtl/core/sorted_grid_interval_search_core.sv =====
// Top level of the sorted grid interval search core: register port, sequencer,
// grid memory and shared compare unit. Depends on sgis_pkg and the sgis_* modules.
//
// Usage. An item is taken when start is high and busy is low. With req_func at
// FUNC_WRITE, req_value is stored at grid entry req_entry_index in that cycle;
// busy stays low and no result follows. With req_func at FUNC_QUERY, req_value
// is the search key: busy rises and the block walks the ascending grid with one
// memory read and one signed compare per cycle, checking the first entry, then
// the last used entry, then bisecting. The result appears on rsp_position for
// one cycle with rsp_valid high; there is no back pressure. A query ends early
// on a bound hit at the first or last used entry or on an exact match; the
// single memory read port sets the pace of the walk. The next item can be
// started in the cycle of the strobe.
// Register grid_count sits at byte address 0 of the APB port; it is to be written
// by the user only while no query is in flight, which the block does not enforce.
// Reset returns the sequencer to idle and sets grid_count to 1024; grid contents
// are not cleared and must be written before they are searched.
module sorted_grid_interval_search_core #(
   parameter int GRID_DEPTH  = sgis_pkg::GRID_DEPTH_DEF,
   parameter int VALUE_WIDTH = sgis_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [sgis_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]   req_value,
   output logic                            rsp_valid,
   output logic [sgis_pkg::POS_W-1:0]      rsp_position,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sgis_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sgis_pkg::CSR_W-1:0]      pwdata,
   output logic [sgis_pkg::CSR_W-1:0]      prdata,
   output logic                            pready
);
   import sgis_pkg::*;

   localparam int IDX_W = $clog2(GRID_DEPTH);

   logic [COUNT_W-1:0]            grid_count_ff;
   logic                          csr_write;
   cmp_res_type                   cmp_res;
   logic signed [VALUE_WIDTH-1:0] key;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [VALUE_WIDTH-1:0]        wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [VALUE_WIDTH-1:0]        rd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_count_ff <= GRID_COUNT_RESET;
      end else if (csr_write && (paddr[2] == CSR_IDX_GRID_COUNT)) begin
         grid_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_IDX_GRID_COUNT) begin
         prdata = CSR_W'(grid_count_ff);
      end else begin
         prdata = '0;
      end
   end

   sgis_seq #(
      .GRID_DEPTH  (GRID_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .grid_count      (grid_count_ff),
      .cmp_res         (cmp_res),
      .key             (key),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rsp_valid       (rsp_valid),
      .rsp_position    (rsp_position)
   );

   sgis_grid_mem #(
      .DEPTH (GRID_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sgis_cmp_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cmp_unit (
      .key   (key),
      .probe (rd_data),
      .res   (cmp_res)
   );

   // A result strobe lasts one cycle and only shows up once the sequencer is idle.
   a_rsp_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held high for more than one cycle");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("rsp_valid raised while a query is still running");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy)
      else $error("grid write issued while a query is running");

endmodule

// ===== test/sorted_grid_interval_search_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted grid interval search core: it mirrors the grid and
// grid_count from the observed transfers and checks each returned position.
// Depends on sgis_pkg only.
module sgis_interval_checker #(
   parameter int GRID_DEPTH  = sgis_pkg::GRID_DEPTH_DEF,
   parameter int VALUE_WIDTH = sgis_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_func,
   input  logic [sgis_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]   req_value,
   input  logic                            rsp_valid,
   input  logic [sgis_pkg::POS_W-1:0]      rsp_position,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sgis_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sgis_pkg::CSR_W-1:0]      pwdata,
   input  logic                            pready,
   output int                              mismatches,
   output int                              outstanding,
   output int                              results_checked
);
   import sgis_pkg::*;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] key;
      logic [POS_W-1:0]              position;
   } query_expect_type;

   query_expect_type              expected_positions [$];
   logic signed [VALUE_WIDTH-1:0] grid_copy [GRID_DEPTH];
   logic [COUNT_W-1:0]            grid_count_copy;

   // Bisection over the used part of the grid with signed compares.
   function automatic logic [POS_W-1:0] interval_of(logic signed [VALUE_WIDTH-1:0] key);
      int used;
      int lo;
      int hi;
      int mid;
      used = int'(grid_count_copy);
      if (used == 0) used = 1;
      if (used > GRID_DEPTH) used = GRID_DEPTH;
      if (key < grid_copy[0]) return '0;
      if (key > grid_copy[used-1]) return POS_W'(used - 1);
      lo = 0;
      hi = used - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (grid_copy[mid] == key) return POS_W'(mid);
         if (grid_copy[mid] < key) lo = mid;
         else hi = mid;
      end
      return POS_W'(lo);
   endfunction

   always @(posedge clock) begin
      query_expect_type head;
      if (reset) begin
         grid_count_copy = GRID_COUNT_RESET;
         expected_positions.delete();
      end else begin
         if (rsp_valid) begin
            results_checked++;
            if (expected_positions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result position %0d with no query waiting", $realtime,
                           rsp_position);
            end else begin
               head = expected_positions.pop_front();
               if (rsp_position !== head.position) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: key %0d position expected %0d, got %0d", $realtime,
                              head.key, head.position, rsp_position);
               end
            end
         end
         if (start && !busy) begin
            if (req_func == FUNC_QUERY)
               expected_positions.push_back('{req_value, interval_of(req_value)});
            else if (req_entry_index < GRID_DEPTH)
               grid_copy[req_entry_index] = req_value;
         end
         if (psel && penable && pwrite && pready &&
             paddr == CSR_ADDR_W'(4 * CSR_IDX_GRID_COUNT))
            grid_count_copy = pwdata[COUNT_W-1:0];
      end
      outstanding = expected_positions.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the sorted grid interval search core: grid fills,
// key queries and grid_count changes. Depends on sgis_pkg, the core and the checker.
module testbench;
   import sgis_pkg::*;

   localparam int VW           = VALUE_WIDTH_DEF;
   localparam int DEPTH        = GRID_DEPTH_DEF;
   localparam int ITEM_TARGET  = 1950;
   localparam int SETTLE       = 20;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_func = FUNC_WRITE;
   logic [INDEX_W-1:0]      req_entry_index = '0;
   logic signed [VW-1:0]    req_value = '0;
   logic                    rsp_valid;
   logic [POS_W-1:0]        rsp_position;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_W-1:0]        pwdata = '0;
   logic [CSR_W-1:0]        prdata;
   logic                    pready;

   int                      mismatches;
   int                      outstanding;
   int                      results_checked;

   // What the stimulus has put in the grid, used only to aim keys and fills.
   logic signed [VW-1:0]    grid_shadow [DEPTH];
   bit                      grid_loaded [DEPTH];
   int                      used_entries;
   int                      items_sent;
   int                      writes_sent;
   int                      queries_sent;
   int                      count_writes;
   int                      count_lo = DEPTH * 2;
   int                      count_hi;
   int                      burst_left;
   bit                      steady;
   int unsigned             cycle_count;
   int                      preset_counts [7] = '{1, 2, 0, 1024, 2047, 3, 33};

   sorted_grid_interval_search_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_entry_index(req_entry_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_position(rsp_position),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sgis_interval_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_entry_index(req_entry_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_position(rsp_position),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding),
      .results_checked(results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_grid_interval_search_core: mismatch");
         $finish;
      end
   end

   // One item transfer; when the current burst has run out, a random gap may come first.
   task automatic send_item(logic func, int idx, logic signed [VW-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = 0;
         if (!steady && $urandom_range(0, 3) != 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start           <= 1'b1;
      req_func        <= func;
      req_entry_index <= idx[INDEX_W-1:0];
      req_value       <= val;
      do @(posedge clock); while (busy);
      items_sent++;
      if (func == FUNC_WRITE) begin
         grid_shadow[idx] = val;
         grid_loaded[idx] = 1'b1;
         writes_sent++;
      end else begin
         queries_sent++;
      end
   endtask

   // Hold the sender off until every query has returned its position.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic set_count(int unsigned cnt);
      drain();
      repeat (SETTLE) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_GRID_COUNT);
      pwdata  <= CSR_W'(cnt[COUNT_W-1:0]);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      count_writes++;
      if (cnt < count_lo) count_lo = cnt;
      if (cnt > count_hi) count_hi = cnt;
      used_entries = (cnt == 0) ? 1 : (cnt > DEPTH) ? DEPTH : cnt;
   endtask

   // Sets grid_count, loads the used entries when needed, then mixes queries
   // with a few stray writes.
   task automatic run_phase(int unsigned cnt);
      int      i;
      int      r;
      int      idx;
      int      n_items;
      bit      in_order;
      bit      all_loaded;
      longint  v;
      longint  step_max;
      longint  k;
      set_count(cnt);
      steady = ($urandom_range(0, 3) == 0);
      all_loaded = 1'b1;
      for (i = 0; i < used_entries; i++)
         if (!grid_loaded[i]) all_loaded = 1'b0;
      if (used_entries <= 64 || !all_loaded) begin
         in_order = !(used_entries <= 64 && $urandom_range(0, 7) == 0);
         case ($urandom_range(0, 3))
            0:       v = longint'(VMIN);
            1:       v = longint'(int'($urandom));
            2:       v = longint'($urandom_range(0, 2000)) - 1000;
            default: v = longint'(int'($urandom)) / 16;
         endcase
         if ($urandom_range(0, 2) == 0) step_max = $urandom_range(0, 8);
         else step_max = $urandom_range(1, (used_entries > 64) ? 4000000 : 400000000);
         for (i = 0; i < used_entries; i++) begin
            send_item(FUNC_WRITE, i, in_order ? v[VW-1:0] : $urandom);
            v += longint'($urandom_range(0, step_max));
            if (v > longint'(VMAX)) v = longint'(VMAX);
         end
      end
      n_items = (used_entries > 64) ? 150 : $urandom_range(20, 60);
      for (i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r == 99) drain();
         if (r < 2) begin
            send_item(FUNC_WRITE, $urandom_range(0, used_entries - 1), $urandom);
         end else if (r < 6 && used_entries < DEPTH) begin
            send_item(FUNC_WRITE, $urandom_range(used_entries, DEPTH - 1), $urandom);
         end else begin
            idx = $urandom_range(0, used_entries - 1);
            r = $urandom_range(0, 99);
            if (r < 30) k = longint'(grid_shadow[idx]);
            else if (r < 45)
               k = longint'(grid_shadow[idx]) + (($urandom_range(0, 1) == 1) ? 1 : -1);
            else if (r < 55)
               k = longint'(grid_shadow[0]) - longint'($urandom_range(1, 70000));
            else if (r < 65)
               k = longint'(grid_shadow[used_entries-1]) + longint'($urandom_range(1, 70000));
            else if (r < 72) k = longint'(VMIN);
            else if (r < 79) k = longint'(VMAX);
            else k = longint'(int'($urandom));
            if (k < longint'(VMIN)) k = longint'(VMIN);
            if (k > longint'(VMAX)) k = longint'(VMAX);
            send_item(FUNC_QUERY, $urandom_range(0, DEPTH - 1), k[VW-1:0]);
         end
      end
   endtask

   initial begin
      logic signed [VW-1:0] ladder [8];
      ladder = '{-32'sd6553600, -32'sd65536, -32'sd1, 32'sd0, 32'sd1, 32'sd98304,
                 32'sd6553600, 32'sh7FFF0000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short ascending grid; keys at the value extremes, on the end entries,
      // on an exact midpoint and between entries.
      set_count(8);
      for (int i = 0; i < 8; i++) send_item(FUNC_WRITE, i, ladder[i]);
      send_item(FUNC_WRITE, DEPTH - 1, $urandom);
      send_item(FUNC_QUERY, 0, VMIN);
      send_item(FUNC_QUERY, DEPTH - 1, VMAX);
      send_item(FUNC_QUERY, 5, ladder[0]);
      send_item(FUNC_QUERY, 0, ladder[7]);
      send_item(FUNC_QUERY, 0, 32'sd0);
      send_item(FUNC_QUERY, 0, 32'sd2);
      send_item(FUNC_QUERY, 0, -32'sd65536);
      // With one entry out of order the bisection simply follows its probes.
      send_item(FUNC_WRITE, 2, 32'sh40000000);
      send_item(FUNC_QUERY, 0, 32'sd0);
      // A count of zero searches a single entry.
      set_count(0);
      send_item(FUNC_QUERY, 0, VMIN);
      send_item(FUNC_QUERY, 0, VMAX);
      send_item(FUNC_QUERY, 0, ladder[0]);

      foreach (preset_counts[p]) run_phase(preset_counts[p]);
      while (items_sent < ITEM_TARGET)
         run_phase(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40));

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d grid writes and %0d key queries; %0d positions came back.",
               writes_sent, queries_sent, results_checked);
      $display("grid_count was set %0d times, from %0d up to %0d.",
               count_writes, count_lo, count_hi);
      if (mismatches == 0 && outstanding == 0) begin
         $display("sorted_grid_interval_search_core: match");
      end else begin
         $display("sorted_grid_interval_search_core: mismatch");
      end
      $finish;
   end

endmodule
